// ===== hw/rtl/smwc_pkg.sv =====
// package for the soil moisture watering controller
// holds field widths, reset values, register and command codes, fsm and control types
// no dependencies
`default_nettype none

package smwc_pkg;

    localparam int ADC_W       = 12;
    localparam int PCT_W       = 7;
    localparam int IDX_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int DIV_NUM_W   = 19;
    localparam int DIV_DEN_W   = 12;
    localparam int DIV_CNT_W   = 5;

    localparam int NUM_SENSORS_DEF = 4;

    localparam logic [PCT_W-1:0] FULL_SCALE    = 7'd100;
    localparam logic [ADC_W-1:0] DRY_RESET     = 12'd4095;
    localparam logic [ADC_W-1:0] WET_RESET     = 12'd0;
    localparam logic [PCT_W-1:0] TRIGGER_RESET = 7'd30;
    localparam logic [PCT_W-1:0] TARGET_RESET  = 7'd60;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DRY     = 2'd0,
        CFG_WET     = 2'd1,
        CFG_TRIGGER = 2'd2,
        CFG_TARGET  = 2'd3
    } cfg_reg_t;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_ROUND  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_SUM,
        ST_DIV,
        ST_STORE,
        ST_DECIDE,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic sample_prep;
        logic sum_clear;
        logic sum_step;
        logic div_load;
        logic reject;
        logic store_write;
        logic decide;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic cmd_round;
        logic sample_ok;
        logic sum_done;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smwc_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// depends on smwc_pkg for operand widths
`default_nettype none

module smwc_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [smwc_pkg::DIV_NUM_W-1:0]  dividend,
    input  wire logic [smwc_pkg::DIV_DEN_W-1:0]  divisor,
    output logic                                 done,
    output logic [smwc_pkg::DIV_NUM_W-1:0]       quotient
);

    localparam int NW = smwc_pkg::DIV_NUM_W;
    localparam int DW = smwc_pkg::DIV_DEN_W;
    localparam int CW = smwc_pkg::DIV_CNT_W;

    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [DW:0]   shifted;
    logic          ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NW-1]};
        ge        = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = CW'(NW);
        end
        else if (cnt_reg != '0)
        begin
            if (ge)
                rem_next = DW'(shifted - {1'b0, den_reg});
            else
                rem_next = shifted[DW-1:0];
            quo_next  = {quo_reg[NW-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
            den_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/smwc_ctrl.sv =====
// sequencing state machine for the watering controller
// depends on smwc_pkg for state, command and status types
`default_nettype none

module smwc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire smwc_pkg::dp_status_t  status,
    output smwc_pkg::dp_cmd_t          cmd
);

    smwc_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= smwc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            smwc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = smwc_pkg::ST_PREP;
                end
            end
            smwc_pkg::ST_PREP:
            begin
                cmd.sample_prep = 1'b1;
                cmd.sum_clear   = 1'b1;
                state_next      = status.cmd_round ? smwc_pkg::ST_SUM : smwc_pkg::ST_CHECK;
            end
            smwc_pkg::ST_CHECK:
            begin
                if (status.sample_ok)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = smwc_pkg::ST_DIV;
                end
                else
                begin
                    cmd.reject = 1'b1;
                    state_next = smwc_pkg::ST_FINISH;
                end
            end
            smwc_pkg::ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (status.sum_done)
                    state_next = smwc_pkg::ST_DECIDE;
            end
            smwc_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = smwc_pkg::ST_STORE;
            end
            smwc_pkg::ST_STORE:
            begin
                cmd.store_write = 1'b1;
                state_next      = smwc_pkg::ST_FINISH;
            end
            smwc_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = smwc_pkg::ST_FINISH;
            end
            smwc_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = smwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smwc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/smwc_dp.sv =====
// datapath: configuration registers, per-sensor percent store, scaling, round sum,
// divider, hysteresis flag and output register; depends on smwc_pkg, smwc_div
`default_nettype none

module smwc_dp #(
    parameter int NUM_SENSORS = smwc_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [smwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [smwc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_command,
    input  wire logic [smwc_pkg::IDX_W-1:0]        in_sensor_index,
    input  wire logic [smwc_pkg::ADC_W-1:0]        in_adc_value,
    input  wire smwc_pkg::dp_cmd_t                 cmd,
    output smwc_pkg::dp_status_t                   status,
    input  wire logic                              out_stall,
    output logic                                   out_valid,
    output logic [smwc_pkg::PCT_W-1:0]             out_percent,
    output logic                                   out_accepted,
    output logic                                   out_water
);

    localparam int ADC_W = smwc_pkg::ADC_W;
    localparam int PCT_W = smwc_pkg::PCT_W;
    localparam int IDX_W = smwc_pkg::IDX_W;
    localparam int NW    = smwc_pkg::DIV_NUM_W;
    localparam int DW    = smwc_pkg::DIV_DEN_W;
    localparam int AW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int CNT_W = $clog2(NUM_SENSORS + 1);
    localparam int SUM_W = $clog2(NUM_SENSORS * 100 + 1);
    // average by reciprocal multiplication, exact for every reachable sum
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int AVG_W    = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SH) + NUM_SENSORS - 1) / NUM_SENSORS);

    // configuration
    logic [ADC_W-1:0] dry_reg, wet_reg;
    logic [PCT_W-1:0] trigger_reg, target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dry_reg     <= smwc_pkg::DRY_RESET;
            wet_reg     <= smwc_pkg::WET_RESET;
            trigger_reg <= smwc_pkg::TRIGGER_RESET;
            target_reg  <= smwc_pkg::TARGET_RESET;
        end
        else if (cfg_write)
        begin
            case (smwc_pkg::cfg_reg_t'(cfg_index))
                smwc_pkg::CFG_DRY:     dry_reg     <= cfg_data[ADC_W-1:0];
                smwc_pkg::CFG_WET:     wet_reg     <= cfg_data[ADC_W-1:0];
                smwc_pkg::CFG_TRIGGER: trigger_reg <= cfg_data[PCT_W-1:0];
                smwc_pkg::CFG_TARGET:  target_reg  <= cfg_data[PCT_W-1:0];
                default:               dry_reg     <= dry_reg;
            endcase
        end
    end

    // request capture
    logic             cmd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [ADC_W-1:0] adc_reg;
    logic             idx_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_command;
            idx_reg <= in_sensor_index;
            adc_reg <= in_adc_value;
        end
    end

    assign idx_ok = (32'(idx_reg) < NUM_SENSORS);

    // scaling
    logic [NW-1:0]    prod_reg;
    logic [DW-1:0]    span_reg;
    logic             ok_reg, idx_ok_reg;
    logic [ADC_W-1:0] diff;

    assign diff = dry_reg - adc_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sample_prep)
        begin
            prod_reg   <= NW'(diff) * NW'(smwc_pkg::FULL_SCALE);
            span_reg   <= dry_reg - wet_reg;
            idx_ok_reg <= idx_ok;
            ok_reg     <= idx_ok && (adc_reg >= wet_reg) && (adc_reg <= dry_reg)
                          && (dry_reg != wet_reg);
        end
    end

    // percent store, unwritten entries read as zero
    logic [PCT_W-1:0]       mem [NUM_SENSORS];
    logic [NUM_SENSORS-1:0] valid_reg;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   rd_ok;
    logic [PCT_W-1:0]       rd_data_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   cnt_in_range;
    logic [NW-1:0]          quotient;

    assign cnt_in_range = (32'(cnt_reg) < NUM_SENSORS);
    assign wr_addr      = AW'(idx_reg);
    assign rd_addr      = cmd.sum_step ? cnt_reg[AW-1:0] : AW'(idx_reg);
    assign rd_ok        = cmd.sum_step ? cnt_in_range : idx_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.store_write)
            mem[wr_addr] <= quotient[PCT_W-1:0];
        if (rd_ok && valid_reg[rd_addr])
            rd_data_reg <= mem[rd_addr];
        else
            rd_data_reg <= '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (cmd.store_write)
            valid_reg[wr_addr] <= 1'b1;
    end

    // round sum, one sensor per cycle behind a registered read
    logic [SUM_W-1:0] sum_reg;
    logic             pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.sum_clear)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.sum_step)
        begin
            pend_reg <= cnt_in_range;
            if (cnt_in_range)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clear)
            sum_reg <= '0;
        else if (cmd.sum_step && pend_reg)
            sum_reg <= sum_reg + SUM_W'(rd_data_reg);
    end

    // divider for the percent mapping
    logic div_done;

    smwc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_load),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // hysteresis decision and result
    logic             watering_reg;
    logic [AVG_W-1:0] avg_prod;
    logic [PCT_W-1:0] avg;
    logic             water;
    logic             watering_next;
    logic [PCT_W-1:0] res_pct_reg;
    logic             res_acc_reg, res_water_reg;

    assign avg_prod = AVG_W'(sum_reg) * AVG_W'(RECIP);
    assign avg      = avg_prod[RECIP_SH +: PCT_W];

    always_comb
    begin
        water         = 1'b0;
        watering_next = watering_reg;
        if (!watering_reg)
        begin
            if ((avg != '0) && (avg <= trigger_reg) && (avg < target_reg))
            begin
                water         = 1'b1;
                watering_next = 1'b1;
            end
        end
        else if (avg < target_reg)
            water = 1'b1;
        else
            watering_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            watering_reg <= 1'b0;
        else if (cmd.decide)
            watering_reg <= watering_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.reject)
        begin
            res_pct_reg   <= idx_ok_reg ? rd_data_reg : '0;
            res_acc_reg   <= 1'b0;
            res_water_reg <= 1'b0;
        end
        else if (cmd.store_write)
        begin
            res_pct_reg   <= quotient[PCT_W-1:0];
            res_acc_reg   <= 1'b1;
            res_water_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            res_pct_reg   <= avg;
            res_acc_reg   <= 1'b0;
            res_water_reg <= water;
        end
    end

    // output register
    logic             out_valid_reg;
    logic [PCT_W-1:0] out_pct_reg;
    logic             out_acc_reg, out_water_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pct_reg   <= res_pct_reg;
            out_acc_reg   <= res_acc_reg;
            out_water_reg <= res_water_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_percent  = out_pct_reg;
    assign out_accepted = out_acc_reg;
    assign out_water    = out_water_reg;

    assign status.cmd_round = (cmd_reg == smwc_pkg::CMD_ROUND);
    assign status.sample_ok = ok_reg;
    assign status.sum_done  = (cnt_reg == CNT_W'(NUM_SENSORS)) && !pend_reg;
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || !out_stall;

endmodule

`default_nettype wire

// ===== hw/rtl/soil_moisture_watering_controller_core.sv =====
// top level of the soil moisture watering controller
// instantiates smwc_ctrl and smwc_dp; uses smwc_pkg for widths and defaults
`default_nettype none

//  channel   handshake              payload
//  ------------------------------------------------------------------------
//  in        in_valid / in_stall    command, sensor_index, adc_value
//  out       out_valid / out_stall  moisture_percent, sample_accepted, water_now
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one request at a time: an in-range sample passes prep, check, the 19-step radix-2 divider,
//  store and finish; a rejected sample goes from check to finish; an end of round sums
//  (reads one stored sensor per cycle), averages by reciprocal multiply and decides
//  in_stall drops from the edge that loads the result; the next request is taken after that edge
//  rst_n resets control state, configuration to defaults, per-sensor valid bits and the watering flag
//  a stalled result blocks the next result, which waits in the finish state, and new requests

module soil_moisture_watering_controller_core #(
    parameter int NUM_SENSORS = smwc_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [smwc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smwc_pkg::CFG_DATA_W-1:0]  cfg_data,

    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             command,
    input  wire logic [smwc_pkg::IDX_W-1:0]       sensor_index,
    input  wire logic [smwc_pkg::ADC_W-1:0]       adc_value,

    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [smwc_pkg::PCT_W-1:0]            moisture_percent,
    output logic                                  sample_accepted,
    output logic                                  water_now
);

    smwc_pkg::dp_cmd_t    cmd;
    smwc_pkg::dp_status_t status;
    logic                 in_ready;

    // registers are always writable; writes must come only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;
    assign in_stall  = !in_ready;

    // sequencer
    smwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // scaling, store, averaging, hysteresis and output register
    smwc_dp #(
        .NUM_SENSORS (NUM_SENSORS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_command      (command),
        .in_sensor_index (sensor_index),
        .in_adc_value    (adc_value),
        .cmd             (cmd),
        .status          (status),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .out_percent     (moisture_percent),
        .out_accepted    (sample_accepted),
        .out_water       (water_now)
    );

endmodule

`default_nettype wire
